### design/arec_pkg.sv
// Shared types and constants for the accelerated rotary encoder counter.
// No dependencies; imported by arec_div and the top level.
package arec_pkg;

  // Width of the gain register, the tick counter and the quotient.
  localparam int GAIN_W = 16;
  localparam int STEP_CNT_W = $clog2(GAIN_W + 1);

  // Configuration register indexes.
  localparam logic REG_BOOST_GAIN     = 1'b0;
  localparam logic REG_PERIOD_CEILING = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  // Status of the serial divider seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### design/arec_div.sv
// Serial restoring divider: one quotient bit per cycle, GAIN_W quotient bits per divide.
// Depends on arec_pkg.
module arec_div import arec_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [GAIN_W-1:0] dividend,
  input  logic [GAIN_W-1:0] divisor,
  output logic [GAIN_W-1:0] quotient,
  output div_status_t       status
);

  logic [GAIN_W-1:0]     rem;
  logic [GAIN_W-1:0]     quo;
  logic [GAIN_W-1:0]     dvs;
  logic [STEP_CNT_W-1:0] steps;
  logic                  busy;
  logic                  done;

  logic [GAIN_W:0] trial;
  logic            fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem, quo[GAIN_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_CNT_W'(GAIN_W);
      end else if (busy) begin
        steps <= steps - STEP_CNT_W'(1);
        if (steps == STEP_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      // A zero divisor is treated as one.
      dvs <= (divisor == '0) ? GAIN_W'(1) : divisor;
    end else if (busy) begin
      rem <= fits ? GAIN_W'(trial - {1'b0, dvs}) : trial[GAIN_W-1:0];
      quo <= {quo[GAIN_W-2:0], fits};
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

### design/accelerated_rotary_encoder_counter.sv
// Accelerated rotary encoder counter, top level; uses arec_pkg and arec_div.
// A plain tick or a preset gives its result in the cycle after accept; a tick with a detent
// goes through ST_DIV and gives its result once the serial divide has finished.
// One item at a time: a new item is taken the cycle after the previous result is taken.
// Reset (rst, synchronous, active high) zeroes count, edges, direction; ticks, regs = 1.
module accelerated_rotary_encoder_counter import arec_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pin_a [0], pin_b [1], preset_value [33:2], zero pad
  input  logic        s_axis_tuser,   // mode [0]: 0 sample tick, 1 preset
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // count [31:0]
  output logic        m_axis_tuser,   // detent [0]
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // Working width for the clamp and saturating add: wide enough for the count,
  // the 32-bit preset and the 16-bit step with headroom, so no sum can wrap.
  localparam int XW = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + GAIN_W + 2;
  localparam logic signed [XW-1:0] CNT_MAX =
    {{(XW - COUNT_WIDTH + 1){1'b0}}, {(COUNT_WIDTH - 1){1'b1}}};
  localparam logic signed [XW-1:0] CNT_MIN = ~CNT_MAX;

  function automatic logic [COUNT_WIDTH-1:0] clamp_count(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    begin
      r = v;
      if (v > CNT_MAX) r = CNT_MAX;
      if (v < CNT_MIN) r = CNT_MIN;
      return r[COUNT_WIDTH-1:0];
    end
  endfunction

  // Configuration registers.
  logic [GAIN_W-1:0] boost_gain;
  logic [GAIN_W-1:0] period_ceiling;

  // Encoder state.
  logic signed [COUNT_WIDTH-1:0] position;
  logic [GAIN_W-1:0]             ticks;
  logic                          last_a;
  logic                          last_b;
  logic                          edge_a;
  logic                          edge_b;
  logic                          direction_down;
  logic                          detent;

  state_t state;
  state_t state_next;

  // Input fields.
  logic                 in_mode;
  logic                 in_a;
  logic                 in_b;
  logic signed [31:0]   in_preset;
  assign in_mode   = s_axis_tuser;
  assign in_a      = s_axis_tdata[0];
  assign in_b      = s_axis_tdata[1];
  assign in_preset = s_axis_tdata[33:2];

  logic s_accept;
  logic m_accept;
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = m_axis_tvalid && m_axis_tready;

  // Tick update, evaluated on the incoming item. The tick counter advances
  // first, then edges are detected against the stored levels; a change on B
  // overrides the direction set by a change on A.
  logic [GAIN_W-1:0] ceiling;
  logic [GAIN_W-1:0] ticks_inc;
  logic              chg_a;
  logic              chg_b;
  logic              edge_a_next;
  logic              edge_b_next;
  logic              direction_next;
  logic              detent_now;

  assign ceiling        = (period_ceiling == '0) ? GAIN_W'(1) : period_ceiling;
  assign ticks_inc      = (ticks < ceiling) ? ticks + GAIN_W'(1) : ticks;
  assign chg_a          = (in_a != last_a);
  assign chg_b          = (in_b != last_b);
  assign edge_a_next    = edge_a || chg_a;
  assign edge_b_next    = edge_b || chg_b;
  assign direction_next = chg_b ? 1'b1 : (chg_a ? 1'b0 : direction_down);
  assign detent_now     = !in_mode && (in_a == in_b) && edge_a_next && edge_b_next;

  // Step size comes from the serial divider: boost_gain / ticks_inc (the advanced tick count).
  logic [GAIN_W-1:0] quotient;
  div_status_t       div_st;

  arec_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (s_accept && detent_now),
    .dividend (boost_gain),
    .divisor  (ticks_inc),
    .quotient (quotient),
    .status   (div_st)
  );

  // Saturating move of the count by the quotient, signed by the direction.
  logic signed [XW-1:0] pos_x;
  logic signed [XW-1:0] step_x;
  logic signed [XW-1:0] moved_x;
  assign pos_x   = XW'(position);
  assign step_x  = {{(XW - GAIN_W){1'b0}}, quotient};
  assign moved_x = direction_down ? (pos_x - step_x) : (pos_x + step_x);

  // Sequencer: idle takes an item, a detent waits out the divide, and the
  // result is held in the output register until it is taken.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_accept) state_next = detent_now ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (div_st.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_accept) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The user must issue configuration writes only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      boost_gain     <= GAIN_W'(1);
      period_ceiling <= GAIN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOOST_GAIN:     boost_gain     <= cfg_data;
        REG_PERIOD_CEILING: period_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      ticks          <= GAIN_W'(1);
      last_a         <= 1'b0;
      last_b         <= 1'b0;
      edge_a         <= 1'b0;
      edge_b         <= 1'b0;
      direction_down <= 1'b0;
      detent         <= 1'b0;
    end else if (s_accept) begin
      last_a <= in_a;
      last_b <= in_b;
      detent <= detent_now;
      if (in_mode) begin
        // Preset leaves the tick counter, edge flags and direction alone.
        position <= clamp_count(XW'(in_preset));
      end else begin
        direction_down <= direction_next;
        if (detent_now) begin
          edge_a <= 1'b0;
          edge_b <= 1'b0;
          ticks  <= '0;
        end else begin
          edge_a <= edge_a_next;
          edge_b <= edge_b_next;
          ticks  <= ticks_inc;
        end
      end
    end else if ((state == ST_DIV) && div_st.done) begin
      position <= clamp_count(moved_x);
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = pos_x[31:0];
  assign m_axis_tuser  = detent;

  // A detent item must start the divider.
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && detent_now) |=> div_st.busy)
    else $error("divider did not start on a detent");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  // A detent result always leaves the tick counter restarted.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (ticks == '0))
    else $error("tick counter not restarted after a detent");

  // A detent result appears only right after the divide completes.
  assert property (@(posedge clk) disable iff (rst)
    ($rose(m_axis_tvalid) && m_axis_tuser) |-> $past(div_st.done))
    else $error("detent result shown before the divide completed");

endmodule
